@@ rtl/core/lbs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants for the four-influence skinning unit.
// ---------------------------------------------------------------------------
package lbs_pkg;

   localparam int JOINTS    = 256;
   localparam int JOINT_W   = 8;
   localparam int ELEMS     = 12;
   localparam int ELEM_W    = 4;
   localparam int LANES     = 4;
   localparam int VAL_W     = 32;
   localparam int WEIGHT_W  = 16;
   localparam int ROW_W     = 51;
   localparam int CONTRIB_W = 70;
   localparam int SUM_W     = 72;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_SKIN  = 1'b1;

   typedef logic signed [VAL_W-1:0]     val_type;
   typedef logic signed [ROW_W-1:0]     row_type;
   typedef logic signed [CONTRIB_W-1:0] contrib_type;
   typedef logic signed [SUM_W-1:0]     sum_type;

   typedef struct packed {
      logic                 command;
      logic [JOINT_W-1:0]   joint_index;
      logic [ELEM_W-1:0]    matrix_element;
      val_type              matrix_value;
      val_type              pos_x;
      val_type              pos_y;
      val_type              pos_z;
      val_type              nrm_x;
      val_type              nrm_y;
      val_type              nrm_z;
      logic [31:0]          bones_packed;
      logic [63:0]          weights_packed;
   } req_type;

   typedef struct packed {
      val_type out_pos_x;
      val_type out_pos_y;
      val_type out_pos_z;
      val_type out_nrm_x;
      val_type out_nrm_y;
      val_type out_nrm_z;
      logic    saturated;
   } rsp_type;

endpackage

@@ rtl/core/linear_blend_vertex_skinning_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_blend_vertex_skinning_unit
// Four-influence linear blend skinning in Q16.16 with a loadable joint table.
// ---------------------------------------------------------------------------
// Takes one item per clock unless the skid is full: a matrix element write
// or a vertex. The pace is set by the four influence lanes, each holding its
// own copy of the joint table as twelve element memories (one read port
// each) feeding a multiply, row sum and weight pipeline. An output register
// with a one-entry skid lets a new item in while a result waits. Joint
// entries read before being written give undefined results.
module linear_blend_vertex_skinning_unit
   import lbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic        adv;
   logic        accept;
   logic        wr_en;
   logic [5:0]  v_ff;
   logic        skid_full_ff;
   rsp_type     skid_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     merged;
   logic        take;
   val_type     pos [0:2];
   val_type     nrm [0:2];
   contrib_type contrib [0:LANES-1][0:5];

   assign adv       = !skid_full_ff;
   assign req_stall = skid_full_ff;
   assign accept    = req_valid && adv;
   assign wr_en     = accept && (req_data.command == CMD_WRITE)
                    && (int'(req_data.matrix_element) < ELEMS)
                    && (int'(req_data.joint_index) < JOINTS);

   assign pos[0] = req_data.pos_x;
   assign pos[1] = req_data.pos_y;
   assign pos[2] = req_data.pos_z;
   assign nrm[0] = req_data.nrm_x;
   assign nrm[1] = req_data.nrm_y;
   assign nrm[2] = req_data.nrm_z;

   genvar k;
   generate
      for (k = 0; k < LANES; k++) begin : g_lane
         lbs_lane u_lane (
            .clock    (clock),
            .adv      (adv),
            .wr_en    (wr_en),
            .wr_joint (req_data.joint_index),
            .wr_elem  (req_data.matrix_element),
            .wr_value (req_data.matrix_value),
            .bone     (req_data.bones_packed[JOINT_W*k +: JOINT_W]),
            .weight   (req_data.weights_packed[WEIGHT_W*k +: WEIGHT_W]),
            .pos      (pos),
            .nrm      (nrm),
            .contrib  (contrib[k])
         );
      end
   endgenerate

   lbs_merge u_merge (
      .clock   (clock),
      .adv     (adv),
      .contrib (contrib),
      .result  (merged)
   );

   assign take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         skid_full_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            v_ff <= {v_ff[4:0], accept && (req_data.command == CMD_SKIN)};
         end
         if (skid_full_ff) begin
            if (take) begin
               rsp_ff       <= skid_ff;
               skid_full_ff <= 1'b0;
            end
         end else if (v_ff[5]) begin
            if (!rsp_valid_ff || take) begin
               rsp_ff       <= merged;
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_ff      <= merged;
               skid_full_ff <= 1'b1;
            end
         end else if (take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/lbs_lane.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbs_lane
// One influence: local copy of the joint table, matrix rows times position
// and normal, then scaling by the influence weight.
// ---------------------------------------------------------------------------
module lbs_lane
   import lbs_pkg::*;
(
   input  logic                clock,
   input  logic                adv,
   input  logic                wr_en,
   input  logic [JOINT_W-1:0]  wr_joint,
   input  logic [ELEM_W-1:0]   wr_elem,
   input  val_type             wr_value,
   input  logic [JOINT_W-1:0]  bone,
   input  logic [WEIGHT_W-1:0] weight,
   input  val_type             pos [0:2],
   input  val_type             nrm [0:2],
   output contrib_type         contrib [0:5]
);

   val_type                m_ff [0:ELEMS-1];
   val_type                pos1_ff [0:2];
   val_type                nrm1_ff [0:2];
   logic [WEIGHT_W-1:0]    w1_ff, w2_ff, w3_ff;
   logic                   en1_ff, en2_ff, en3_ff, en4_ff;
   logic signed [63:0]     prod_ff [0:5][0:2];
   val_type                m3_ff [0:2];
   row_type                t_ff [0:5];
   logic [47:0]            lo_ff [0:5];
   logic signed [35:0]     hi_ff [0:5];
   contrib_type            contrib_ff [0:5];
   logic signed [66:0]     row_sum [0:5];

   // one memory per matrix element, all written with the same joint address
   genvar e;
   generate
      for (e = 0; e < ELEMS; e++) begin : g_mem
         logic [VAL_W-1:0] mem_ff [0:JOINTS-1];
         always_ff @(posedge clock) begin
            if (wr_en && (wr_elem == ELEM_W'(e))) begin
               mem_ff[wr_joint] <= wr_value;
            end
            if (adv) begin
               m_ff[e] <= val_type'(mem_ff[bone]);
            end
         end
      end
   endgenerate

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_sum[r] = 67'(prod_ff[r][0]) + 67'(prod_ff[r][1]) + 67'(prod_ff[r][2])
                    + (67'(m3_ff[r]) <<< 16) + 67'(32768);
         row_sum[3+r] = 67'(prod_ff[3+r][0]) + 67'(prod_ff[3+r][1])
                      + 67'(prod_ff[3+r][2]) + 67'(32768);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos1_ff <= pos;
         nrm1_ff <= nrm;
         w1_ff   <= weight;
         en1_ff  <= (weight != '0) && (int'(bone) < JOINTS);

         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c]   <= m_ff[r*4+c] * pos1_ff[c];
               prod_ff[3+r][c] <= m_ff[r*4+c] * nrm1_ff[c];
            end
            m3_ff[r] <= m_ff[r*4+3];
         end
         w2_ff  <= w1_ff;
         en2_ff <= en1_ff;

         for (int i = 0; i < 6; i++) begin
            t_ff[i] <= row_sum[i][66:16];
         end
         w3_ff  <= w2_ff;
         en3_ff <= en2_ff;

         // split the row value so each weight product stays narrow
         for (int i = 0; i < 6; i++) begin
            lo_ff[i] <= t_ff[i][31:0] * w3_ff;
            hi_ff[i] <= $signed(t_ff[i][ROW_W-1:32]) * $signed({1'b0, w3_ff});
         end
         en4_ff <= en3_ff;

         for (int i = 0; i < 6; i++) begin
            contrib_ff[i] <= en4_ff ?
               contrib_type'((CONTRIB_W'(hi_ff[i]) <<< 32) + CONTRIB_W'(lo_ff[i])) : '0;
         end
      end
   end

   assign contrib = contrib_ff;

endmodule

@@ rtl/core/lbs_merge.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lbs_merge
// Sums the lane contributions, rounds to Q16.16 and saturates.
// ---------------------------------------------------------------------------
module lbs_merge
   import lbs_pkg::*;
(
   input  logic        clock,
   input  logic        adv,
   input  contrib_type contrib [0:LANES-1][0:5],
   output rsp_type     result
);

   sum_type             sum_ff [0:5];
   sum_type             rnd [0:5];
   logic signed [56:0]  q [0:5];
   val_type             sat [0:5];
   logic [5:0]          clip;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 6; i++) begin
            sum_ff[i] <= SUM_W'(contrib[0][i]) + SUM_W'(contrib[1][i])
                       + SUM_W'(contrib[2][i]) + SUM_W'(contrib[3][i]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         rnd[i] = sum_ff[i] + SUM_W'(16384);
         q[i]   = rnd[i][71:15];
         // in range when all bits above bit 31 match the sign
         if ((q[i][56:31] == '0) || (q[i][56:31] == '1)) begin
            clip[i] = 1'b0;
            sat[i]  = q[i][31:0];
         end else begin
            clip[i] = 1'b1;
            sat[i]  = q[i][56] ? val_type'(32'h8000_0000) : val_type'(32'h7FFF_FFFF);
         end
      end
      result.out_pos_x = sat[0];
      result.out_pos_y = sat[1];
      result.out_pos_z = sat[2];
      result.out_nrm_x = sat[3];
      result.out_nrm_y = sat[4];
      result.out_nrm_z = sat[5];
      result.saturated = |clip;
   end

endmodule
